// ===== hw/rtl/dcc_pkg.sv =====
// shared types, constants and helpers of the depthwise causal convolution block
`default_nettype none
package dcc_pkg;

  localparam int CHANNELS_DEFAULT = 256;
  localparam int TAPS_DEFAULT     = 4;

  localparam int CH_BITS    = 8;
  localparam int TAP_BITS   = 2;
  localparam int VAL_BITS   = 16;
  localparam int PROD_BITS  = 32;
  localparam int RES_BITS   = 36;
  localparam int KLEN_BITS  = 3;
  localparam logic [KLEN_BITS-1:0] KLEN_RESET = 3'd4;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic                       is_sample;
    logic [CH_BITS-1:0]         ch;
    logic [TAP_BITS-1:0]        tap;
    logic signed [VAL_BITS-1:0] value;
    logic                       first;
  } cmd_t;

  typedef struct packed {
    logic [CH_BITS-1:0]         ch;
    logic signed [RES_BITS-1:0] result;
  } res_t;

  // number of history samples kept per channel
  function automatic int hist_len(input int taps);
    return (taps > 1) ? taps - 1 : 1;
  endfunction

  // width of a fill count that saturates at taps-1
  function automatic int fill_width(input int taps);
    return (taps > 1) ? $clog2(taps) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dcc_queue.sv =====
// small register fifo with registered entries
`default_nettype none
module dcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty,
  output logic      [CW-1:0]    count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dcc_front.sv =====
// front end: input handshake, item classification and the kernel length register
`default_nettype none
module dcc_front #(
  parameter int CHANNELS = dcc_pkg::CHANNELS_DEFAULT,
  parameter int TAPS     = dcc_pkg::TAPS_DEFAULT,
  localparam int FC_W    = dcc_pkg::fill_width(TAPS)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            opcode,
  input  wire logic [dcc_pkg::CH_BITS-1:0]     channel,
  input  wire logic [dcc_pkg::TAP_BITS-1:0]    tap,
  input  wire logic signed [dcc_pkg::VAL_BITS-1:0] value,
  input  wire logic                            first,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dcc_pkg::KLEN_BITS-1:0]   taps_in_use,
  output logic                                 q_wr,
  output dcc_pkg::cmd_t                        q_cmd,
  input  wire logic                            q_full,
  input  wire logic                            clearing,
  output logic      [FC_W-1:0]                 km1
);

  localparam logic [12:0] CH_LIM  = 13'(CHANNELS);
  localparam logic [4:0]  TAP_LIM = 5'(TAPS);
  localparam logic [4:0]  TOP     = 5'(TAPS - 1);

  logic [dcc_pkg::KLEN_BITS-1:0] klen;
  logic [4:0] klen5;
  logic [4:0] km1_5;
  logic       accept;
  logic       ch_ok;
  logic       tap_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      klen <= dcc_pkg::KLEN_RESET;
    end else if (cfg_valid) begin
      klen <= taps_in_use;
    end
  end

  // clamp the kernel length into 1..TAPS and hand on K-1
  always_comb begin
    klen5 = 5'(klen);
    if (klen5 == 5'd0) begin
      km1_5 = 5'd0;
    end else if (klen5 > TAP_LIM) begin
      km1_5 = TOP;
    end else begin
      km1_5 = klen5 - 5'd1;
    end
    km1 = km1_5[FC_W-1:0];
  end

  assign full   = q_full || clearing;
  assign accept = push && !full;
  assign ch_ok  = (13'(channel) < CH_LIM);
  assign tap_ok = (5'(tap) < TAP_LIM);

  // out-of-range items are taken and dropped here
  assign q_wr = accept && ch_ok && ((opcode == dcc_pkg::OP_SAMPLE) || tap_ok);

  always_comb begin
    q_cmd.is_sample = (opcode == dcc_pkg::OP_SAMPLE);
    q_cmd.ch        = channel;
    q_cmd.tap       = tap;
    q_cmd.value     = value;
    q_cmd.first     = first;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dcc_back.sv =====
// back end: weight, history and fill memories, tap multipliers and the sum stage
`default_nettype none
module dcc_back #(
  parameter int CHANNELS = dcc_pkg::CHANNELS_DEFAULT,
  parameter int TAPS     = dcc_pkg::TAPS_DEFAULT,
  localparam int FC_W    = dcc_pkg::fill_width(TAPS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dcc_pkg::cmd_t               q_cmd,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic [FC_W-1:0]             km1,
  input  wire logic [dcc_pkg::OUT_CW-1:0]  out_count,
  output logic                             out_wr,
  output dcc_pkg::res_t                    out_data,
  output logic                             clearing
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST = dcc_pkg::hist_len(TAPS);
  localparam int VW   = dcc_pkg::VAL_BITS;
  localparam int HW   = HIST * VW;
  localparam logic [4:0]      TOP      = 5'(TAPS - 1);
  localparam logic [FC_W-1:0] FILL_MAX = FC_W'(TAPS - 1);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNELS - 1);

  function automatic logic [CH_W-1:0] to_addr(input logic [dcc_pkg::CH_BITS-1:0] ch);
    logic [CH_W+dcc_pkg::CH_BITS-1:0] t;
    t = {{CH_W{1'b0}}, ch};
    return t[CH_W-1:0];
  endfunction

  logic [CH_W-1:0] pop_addr;
  logic            pop_sample;
  logic [dcc_pkg::OUT_CW+1:0] credit_need;

  // stage m: memory read data and the sample
  logic                   m_valid;
  logic [CH_W-1:0]        m_addr;
  logic [dcc_pkg::CH_BITS-1:0] m_ch;
  logic signed [VW-1:0]   m_val;
  logic                   m_first;
  logic signed [VW-1:0]   m_w [TAPS];
  logic [HW-1:0]          hist_rd;
  logic [FC_W-1:0]        fill_rd;

  // last history write, for a sample of the same channel right behind it
  logic                   fwd_valid;
  logic [CH_W-1:0]        fwd_addr;
  logic [HW-1:0]          fwd_hist;
  logic [FC_W-1:0]        fwd_fill;
  logic                   fwd_hit;

  logic [HW-1:0]          hist_cur;
  logic [HW-1:0]          hist_new;
  logic [FC_W-1:0]        fill_cur;
  logic [FC_W-1:0]        fill_new;
  logic                   ready;
  logic signed [VW-1:0]   win    [TAPS];
  logic signed [VW-1:0]   lane_a [TAPS];
  logic signed [VW-1:0]   lane_b [TAPS];

  // stage s: products
  logic                   s_valid;
  logic [dcc_pkg::CH_BITS-1:0] s_ch;
  logic signed [dcc_pkg::PROD_BITS-1:0] s_prod [TAPS];
  logic signed [dcc_pkg::RES_BITS-1:0]  sum;

  logic [CH_W-1:0] clr_addr;

  logic [HW-1:0]   hist_mem [CHANNELS];
  logic [FC_W-1:0] fill_mem [CHANNELS];

  assign pop_addr   = to_addr(q_cmd.ch);
  assign pop_sample = q_pop && q_cmd.is_sample;

  // room in the result queue for this item and all still in flight
  assign credit_need = (dcc_pkg::OUT_CW + 2)'(out_count) + (dcc_pkg::OUT_CW + 2)'(m_valid)
                     + (dcc_pkg::OUT_CW + 2)'(s_valid) + 1'b1;
  assign q_pop = !q_empty && !clearing
              && (credit_need <= (dcc_pkg::OUT_CW + 2)'(dcc_pkg::OUT_DEPTH));

  // fill count clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CH_LAST) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // weights are written when popped, so a later sample always sees them
  for (genvar j = 0; j < TAPS; j++) begin : g_wbank
    logic signed [VW-1:0] wmem [CHANNELS];
    always_ff @(posedge clk) begin
      if (q_pop && !q_cmd.is_sample && (5'(q_cmd.tap) == 5'(j))) begin
        wmem[pop_addr] <= q_cmd.value;
      end
      if (pop_sample) begin
        m_w[j] <= wmem[pop_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_sample) begin
      hist_rd <= hist_mem[pop_addr];
    end
    if (m_valid) begin
      hist_mem[m_addr] <= hist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_sample) begin
      fill_rd <= fill_mem[pop_addr];
    end
    if (clearing) begin
      fill_mem[clr_addr] <= '0;
    end else if (m_valid) begin
      fill_mem[m_addr] <= fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      s_valid   <= 1'b0;
    end else begin
      m_valid   <= pop_sample;
      fwd_valid <= m_valid;
      s_valid   <= m_valid && ready;
    end
  end

  always_ff @(posedge clk) begin
    m_addr   <= pop_addr;
    m_ch     <= q_cmd.ch;
    m_val    <= q_cmd.value;
    m_first  <= q_cmd.first;
    fwd_addr <= m_addr;
    fwd_hist <= hist_new;
    fwd_fill <= fill_new;
    s_ch     <= m_ch;
  end

  assign fwd_hit  = fwd_valid && (fwd_addr == m_addr);
  assign hist_cur = fwd_hit ? fwd_hist : hist_rd;

  always_comb begin
    if (m_first) begin
      fill_cur = '0;
    end else if (fwd_hit) begin
      fill_cur = fwd_fill;
    end else begin
      fill_cur = fill_rd;
    end
    ready    = (fill_cur >= km1);
    fill_new = (fill_cur == FILL_MAX) ? fill_cur : fill_cur + 1'b1;
  end

  // window: oldest history sample first, current sample last
  for (genvar n = 0; n < TAPS; n++) begin : g_win
    if (n == TAPS - 1) begin : g_cur
      assign win[n] = m_val;
    end else begin : g_old
      assign win[n] = hist_cur[VW*n +: VW];
    end
  end

  for (genvar n = 0; n < HIST; n++) begin : g_shift
    if (n == HIST - 1) begin : g_in
      assign hist_new[VW*n +: VW] = m_val;
    end else begin : g_mv
      assign hist_new[VW*n +: VW] = hist_cur[VW*(n+1) +: VW];
    end
  end

  // weight j pairs with window position TAPS-K+j, unused lanes get zero on both sides
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      lane_a[j] = '0;
      lane_b[j] = '0;
      if (5'(j) <= 5'(km1)) begin
        lane_b[j] = m_w[j];
      end
      for (int n = 0; n < TAPS; n++) begin
        if ((5'(j) <= 5'(km1)) && (5'(j) + TOP - 5'(km1) == 5'(n))) begin
          lane_a[j] = win[n];
        end
      end
    end
  end

  for (genvar j = 0; j < TAPS; j++) begin : g_mul
    always_ff @(posedge clk) begin
      s_prod[j] <= lane_a[j] * lane_b[j];
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < TAPS; j++) begin
      sum = sum + dcc_pkg::RES_BITS'(s_prod[j]);
    end
  end

  assign out_wr          = s_valid;
  assign out_data.ch     = s_ch;
  assign out_data.result = sum;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("item popped during fill clearing pass");

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> (out_count < dcc_pkg::OUT_CW'(dcc_pkg::OUT_DEPTH)))
    else $error("result written into a full result queue");

  a_m_from_pop: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> $past(q_pop && q_cmd.is_sample))
    else $error("sample stage valid without a popped sample");

endmodule
`default_nettype wire

// ===== hw/rtl/depthwise_causal_conv1d.sv =====
// top level of the depthwise causal convolution block
`default_nettype none
// Depthwise causal FIR: weight items load one tap of one channel, sample items
// produce a Q10.26 result once the channel has seen a full window of
// taps_in_use samples. One item is accepted per cycle while the result queue has room;
// a result passes from the internal command queue through the m stage registers,
// the s stage product registers and the result queue to the result ports. The rate
// is set by the single read and write port of the per-channel history memory,
// which is read once per sample as one wide word and rewritten in the next cycle,
// with a bypass for a sample of the same channel directly behind. After reset
// full stays high while the fill counts are cleared; the configuration port is
// taken at any time.
module depthwise_causal_conv1d #(
  parameter int CHANNELS = dcc_pkg::CHANNELS_DEFAULT,
  parameter int TAPS     = dcc_pkg::TAPS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              opcode,
  input  wire logic [dcc_pkg::CH_BITS-1:0]       channel,
  input  wire logic [dcc_pkg::TAP_BITS-1:0]      tap,
  input  wire logic signed [dcc_pkg::VAL_BITS-1:0] value,
  input  wire logic                              first,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic      [dcc_pkg::CH_BITS-1:0]       out_channel,
  output logic signed [dcc_pkg::RES_BITS-1:0]    result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dcc_pkg::KLEN_BITS-1:0]     taps_in_use
);

  localparam int FC_W = dcc_pkg::fill_width(TAPS);
  localparam int CMD_W = $bits(dcc_pkg::cmd_t);
  localparam int RES_W = $bits(dcc_pkg::res_t);

  logic                 mid_wr;
  dcc_pkg::cmd_t        mid_in;
  logic                 mid_full;
  logic                 mid_pop;
  logic [CMD_W-1:0]     mid_out_bits;
  dcc_pkg::cmd_t        mid_out;
  logic                 mid_empty;
  logic                 clearing;
  logic [FC_W-1:0]      km1;
  logic                 res_wr;
  dcc_pkg::res_t        res_in;
  logic [RES_W-1:0]     res_out_bits;
  dcc_pkg::res_t        res_out;
  logic [dcc_pkg::OUT_CW-1:0] res_count;

  dcc_front #(
    .CHANNELS (CHANNELS),
    .TAPS     (TAPS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .channel     (channel),
    .tap         (tap),
    .value       (value),
    .first       (first),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .taps_in_use (taps_in_use),
    .q_wr        (mid_wr),
    .q_cmd       (mid_in),
    .q_full      (mid_full),
    .clearing    (clearing),
    .km1         (km1)
  );

  dcc_queue #(
    .WIDTH (CMD_W),
    .DEPTH (dcc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_data (mid_in),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_out_bits),
    .empty   (mid_empty),
    .count   ()
  );

  assign mid_out = mid_out_bits;

  dcc_back #(
    .CHANNELS (CHANNELS),
    .TAPS     (TAPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_cmd     (mid_out),
    .q_empty   (mid_empty),
    .q_pop     (mid_pop),
    .km1       (km1),
    .out_count (res_count),
    .out_wr    (res_wr),
    .out_data  (res_in),
    .clearing  (clearing)
  );

  dcc_queue #(
    .WIDTH (RES_W),
    .DEPTH (dcc_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (),
    .rd_en   (pop),
    .rd_data (res_out_bits),
    .empty   (empty),
    .count   (res_count)
  );

  assign res_out     = res_out_bits;
  assign out_channel = res_out.ch;
  assign result      = res_out.result;

endmodule
`default_nettype wire
